[rtl/dfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited frame receiver package
// Shared constants, codes and types for the frame receiver.
// ----------------------------------------------------------------------------
package dfr_pkg;

  // Default sizing of the frame store.
  localparam int MAX_FRAME_DEF = 64;
  localparam int NUM_SLOTS_DEF = 3;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_A   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_B   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_C   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO    = 3'd6;

  // Register reset values.
  localparam logic [7:0] START_A_RST = 8'd91;
  localparam logic [7:0] START_B_RST = 8'd91;
  localparam logic [7:0] START_C_RST = 8'd123;
  localparam logic [7:0] END_A_RST   = 8'd93;
  localparam logic [7:0] END_B_RST   = 8'd93;
  localparam logic [7:0] END_C_RST   = 8'd125;

  // Request operations.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_ECHO   = 2'd0;
  localparam logic [1:0] KIND_STORED = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // Delimiter pair codes.
  typedef logic [1:0] pair_t;
  localparam pair_t PAIR_NONE = 2'd0;
  localparam pair_t PAIR_A    = 2'd1;
  localparam pair_t PAIR_B    = 2'd2;
  localparam pair_t PAIR_C    = 2'd3;

  // Control sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

[rtl/dfr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data register holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/delimited_frame_receiver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited frame receiver
// A byte request's echo or frame-stored result appears on the master side the
// cycle after acceptance. A non-empty read passes the read context, RAM data
// and output registers, then yields one byte per cycle while the master side
// accepts, set by the single read port of the frame RAM; the next request is
// taken after the last byte has left the RAM. Reset is synchronous: control
// state clears, slot lengths read zero and the slot counter points at the last
// slot; no clearing pass is run, and RAM content is undefined until written.
// ----------------------------------------------------------------------------
module delimited_frame_receiver #(
  parameter int MAX_FRAME = dfr_pkg::MAX_FRAME_DEF,
  parameter int NUM_SLOTS = dfr_pkg::NUM_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration write port
  input  logic                         cfg_we,
  input  logic [dfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dfr_pkg::CFG_DATA_W-1:0] cfg_data,
  // Request stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [15:0]                  s_tdata,   // rx_byte[7:0], armed[8], zero pad
  input  logic [0:0]                   s_tuser,   // op[0]
  // Result stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [23:0]                  m_tdata,   // data_byte[7:0], slot[9:8],
                                                  // frame_length[16:10], overflow[17],
                                                  // empty_res[18], zero pad
  output logic [1:0]                   m_tuser,   // kind[1:0]
  output logic                         m_tlast
);

  import dfr_pkg::*;

  localparam int IDX_W  = $clog2(MAX_FRAME);
  localparam int LEN_W  = $clog2(MAX_FRAME + 1);
  localparam int SIDX_W = $clog2(NUM_SLOTS);
  localparam int PHYS_W = $clog2(NUM_SLOTS + 1);
  localparam int SLOT_W = $clog2(NUM_SLOTS + 1);
  localparam int RAM_DEPTH = (NUM_SLOTS + 1) * (2 ** IDX_W);
  localparam int RAM_AW    = PHYS_W + IDX_W;

  localparam logic [SIDX_W-1:0] SIDX_LAST = SIDX_W'(NUM_SLOTS - 1);
  localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(MAX_FRAME);

  // Configuration registers.
  logic [7:0] start_a, start_b, start_c;
  logic [7:0] end_a, end_b, end_c;
  logic       echo_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_a <= START_A_RST;
      start_b <= START_B_RST;
      start_c <= START_C_RST;
      end_a   <= END_A_RST;
      end_b   <= END_B_RST;
      end_c   <= END_C_RST;
      echo_en <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_A: start_a <= cfg_data[7:0];
        REG_START_B: start_b <= cfg_data[7:0];
        REG_START_C: start_c <= cfg_data[7:0];
        REG_END_A:   end_a   <= cfg_data[7:0];
        REG_END_B:   end_b   <= cfg_data[7:0];
        REG_END_C:   end_c   <= cfg_data[7:0];
        REG_ECHO:    echo_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Request fields.
  logic       op;
  logic [7:0] rx;
  logic       arm_in;
  logic       accept;

  assign op     = s_tuser[0];
  assign rx     = s_tdata[7:0];
  assign arm_in = s_tdata[8];
  assign accept = s_tvalid & s_tready;

  // Frame state. The RAM holds NUM_SLOTS + 1 physical buffers: one collects
  // the open frame, the others back the logical slots through slot_map. A
  // completed frame is stored by swapping its buffer into the target slot.
  logic                  approval, approval_next;
  logic                  in_frame, in_frame_next;
  pair_t                 pair, pair_next;
  logic [LEN_W-1:0]      work_length, work_length_next;
  logic                  work_ovf, work_ovf_next;
  logic [PHYS_W-1:0]     work_phys, work_phys_next;
  logic [SIDX_W-1:0]     cnt, cnt_next;
  logic [PHYS_W-1:0]     slot_map [NUM_SLOTS];
  logic [PHYS_W-1:0]     slot_map_next [NUM_SLOTS];
  logic [LEN_W-1:0]      slot_len [NUM_SLOTS];
  logic [LEN_W-1:0]      slot_len_next [NUM_SLOTS];

  // Read sequencer state.
  state_t                state, state_next;
  logic [PHYS_W-1:0]     rd_phys;
  logic [LEN_W-1:0]      rd_len;
  logic [SIDX_W-1:0]     rd_slot;
  logic [LEN_W-1:0]      rd_idx;
  logic                  rd_pending;
  logic                  rd_last;
  logic                  rd_issue;
  logic                  rd_load;
  logic                  rd_done;

  // Output register.
  logic                  out_free;
  logic [1:0]            out_kind;
  logic [7:0]            out_data;
  logic [1:0]            out_slot;
  logic [6:0]            out_len;
  logic                  out_ovf;
  logic                  out_empty;
  logic                  out_last;

  // Immediate result of a request (echo, frame stored, empty read).
  logic                  res_valid;
  logic [1:0]            res_kind;
  logic [7:0]            res_data;
  logic [SLOT_W-1:0]     res_slot;
  logic [LEN_W-1:0]      res_len;
  logic                  res_ovf;
  logic                  res_empty;

  // RAM ports.
  logic                  wr_en;
  logic [RAM_AW-1:0]     wr_addr;
  logic [RAM_AW-1:0]     rd_addr;
  logic [7:0]            ram_rdata;

  // Delimiter matching.
  logic                  appr_eff;
  pair_t                 start_match;
  logic                  is_end;
  logic                  room;
  logic [LEN_W-1:0]      len_upd;
  logic [SIDX_W-1:0]     tgt;

  assign out_free = !m_tvalid || m_tready;
  assign appr_eff = approval || arm_in;
  assign room     = (work_length < LEN_MAX);
  assign len_upd  = room ? (work_length + LEN_W'(1)) : work_length;
  assign tgt      = (cnt == SIDX_LAST) ? '0 : (cnt + SIDX_W'(1));

  always_comb begin
    if (rx == start_a) begin
      start_match = PAIR_A;
    end else if (rx == start_b) begin
      start_match = PAIR_B;
    end else if (rx == start_c) begin
      start_match = PAIR_C;
    end else begin
      start_match = PAIR_NONE;
    end
  end

  assign is_end = ((pair == PAIR_A) && (rx == end_a)) ||
                  ((pair == PAIR_B) && (rx == end_b)) ||
                  ((pair == PAIR_C) && (rx == end_c));

  // Request handling: frame collection, slot bookkeeping and short results.
  always_comb begin
    approval_next    = approval;
    in_frame_next    = in_frame;
    pair_next        = pair;
    work_length_next = work_length;
    work_ovf_next    = work_ovf;
    work_phys_next   = work_phys;
    cnt_next         = cnt;
    slot_map_next    = slot_map;
    slot_len_next    = slot_len;
    wr_en            = 1'b0;
    wr_addr          = {work_phys, work_length[IDX_W-1:0]};
    res_valid        = 1'b0;
    res_kind         = KIND_ECHO;
    res_data         = '0;
    res_slot         = '0;
    res_len          = '0;
    res_ovf          = 1'b0;
    res_empty        = 1'b0;

    if (accept) begin
      if (arm_in) begin
        approval_next = 1'b1;
      end
      if (op == OP_READ) begin
        // Read the slot under the counter, then step the counter back.
        cnt_next = (cnt == '0) ? SIDX_LAST : (cnt - SIDX_W'(1));
        if (slot_len[cnt] == '0) begin
          res_valid = 1'b1;
          res_kind  = KIND_READ;
          res_slot  = SLOT_W'(cnt) + SLOT_W'(1);
          res_empty = 1'b1;
        end
      end else if (!in_frame) begin
        // Outside a frame and when armed: look for a start delimiter, else echo if enabled.
        if (appr_eff) begin
          if (start_match != PAIR_NONE) begin
            in_frame_next    = 1'b1;
            pair_next        = start_match;
            wr_en            = 1'b1;
            wr_addr          = {work_phys, IDX_W'(0)};
            work_length_next = LEN_W'(1);
            work_ovf_next    = 1'b0;
          end else if (echo_en) begin
            res_valid = 1'b1;
            res_kind  = KIND_ECHO;
            res_data  = rx;
          end
        end
      end else begin
        // Inside a frame: append while there is room, flag the rest.
        if (room) begin
          wr_en = 1'b1;
        end else begin
          work_ovf_next = 1'b1;
        end
        work_length_next = len_upd;
        if (is_end) begin
          // Hand the collecting buffer to the next slot and take its old one.
          cnt_next           = tgt;
          slot_map_next[tgt] = work_phys;
          work_phys_next     = slot_map[tgt];
          slot_len_next[tgt] = len_upd;
          res_valid          = 1'b1;
          res_kind           = KIND_STORED;
          res_slot           = SLOT_W'(tgt) + SLOT_W'(1);
          res_len            = len_upd;
          res_ovf            = work_ovf || !room;
          in_frame_next      = 1'b0;
          approval_next      = 1'b0;
          pair_next          = PAIR_NONE;
          work_length_next   = '0;
          work_ovf_next      = 1'b0;
        end
      end
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      approval    <= 1'b0;
      in_frame    <= 1'b0;
      pair        <= PAIR_NONE;
      work_length <= '0;
      work_ovf    <= 1'b0;
      work_phys   <= PHYS_W'(NUM_SLOTS);
      cnt         <= SIDX_LAST;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_map[i] <= PHYS_W'(i);
        slot_len[i] <= '0;
      end
    end else begin
      approval    <= approval_next;
      in_frame    <= in_frame_next;
      pair        <= pair_next;
      work_length <= work_length_next;
      work_ovf    <= work_ovf_next;
      work_phys   <= work_phys_next;
      cnt         <= cnt_next;
      slot_map    <= slot_map_next;
      slot_len    <= slot_len_next;
    end
  end

  // Read sequencer: next state.
  assign rd_done = (rd_idx == rd_len) && !rd_pending;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (op == OP_READ) && (slot_len[cnt] != '0)) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Read sequencer: outputs. A RAM read is issued when the RAM data register holds
  // no pending byte, or when its byte leaves for the output register in the same cycle.
  always_comb begin
    s_tready = 1'b0;
    rd_load  = 1'b0;
    rd_issue = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = out_free;
      end
      ST_READ: begin
        rd_load  = rd_pending && out_free;
        rd_issue = (rd_idx != rd_len) && (!rd_pending || rd_load);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rd_pending <= 1'b0;
    end else begin
      state <= state_next;
      if (rd_issue) begin
        rd_pending <= 1'b1;
      end else if (rd_load) begin
        rd_pending <= 1'b0;
      end
    end
  end

  // Read context, captured when a read request is taken.
  always_ff @(posedge clk) begin
    if (accept && (op == OP_READ)) begin
      rd_phys <= slot_map[cnt];
      rd_len  <= slot_len[cnt];
      rd_slot <= cnt;
      rd_idx  <= '0;
    end else if (rd_issue) begin
      rd_idx  <= rd_idx + LEN_W'(1);
      rd_last <= (rd_idx == (rd_len - LEN_W'(1)));
    end
  end

  assign rd_addr = {rd_phys, rd_idx[IDX_W-1:0]};

  // Frame RAM. Writes happen only while idle and reads only while reading,
  // so the two ports never touch the same entry in one cycle.
  dfr_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (rx),
    .re    (rd_issue),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid || rd_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_kind  <= res_kind;
      out_data  <= res_data;
      out_slot  <= 2'(res_slot);
      out_len   <= 7'(res_len);
      out_ovf   <= res_ovf;
      out_empty <= res_empty;
      out_last  <= 1'b1;
    end else if (rd_load) begin
      out_kind  <= KIND_READ;
      out_data  <= ram_rdata;
      out_slot  <= 2'(SLOT_W'(rd_slot) + SLOT_W'(1));
      out_len   <= 7'(rd_len);
      out_ovf   <= 1'b0;
      out_empty <= 1'b0;
      out_last  <= rd_last;
    end
  end

  assign m_tdata = {5'd0, out_empty, out_ovf, out_len, out_slot, out_data};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule
